/* src/hamming74_packed_decoder_unit_macros.svh */
// Assertion helpers shared by the decoder modules.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef HAMMING74_PACKED_DECODER_UNIT_MACROS_SVH
`define HAMMING74_PACKED_DECODER_UNIT_MACROS_SVH

// Same-cycle implication.
`define HPD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HPD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/hpd_pkg.sv */
package hpd_pkg;

  // Syndrome masks over one 7-bit codeword
  localparam logic [6:0] SynMask0 = 7'd105;
  localparam logic [6:0] SynMask1 = 7'd58;
  localparam logic [6:0] SynMask2 = 7'd116;

  // Syndromes that point at a data bit
  localparam logic [2:0] SynData0 = 3'd3;
  localparam logic [2:0] SynData1 = 3'd6;
  localparam logic [2:0] SynData2 = 3'd7;
  localparam logic [2:0] SynData3 = 3'd5;

  localparam int unsigned CwWidth   = 7;
  localparam int unsigned WinWidth  = 14;
  localparam int unsigned StoreW    = 6;
  localparam int unsigned PendCntW  = 3;
  // Pending bits that let one byte complete two codewords
  localparam logic [PendCntW-1:0] PendFull = 3'd6;

  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_out;
  } hpd_result_t;

  // Up to two results produced by one input byte, a before b
  typedef struct packed {
    logic        valid_a;
    logic        valid_b;
    hpd_result_t res_a;
    hpd_result_t res_b;
  } hpd_push_t;

  function automatic logic [3:0] hpd_decode_cw(input logic [CwWidth-1:0] cw);
    logic [2:0]         syn;
    logic [CwWidth-1:0] fixed;
    syn[0] = ^(cw & SynMask0);
    syn[1] = ^(cw & SynMask1);
    syn[2] = ^(cw & SynMask2);
    fixed  = cw;
    case (syn)
      SynData0: fixed[3] = ~cw[3];
      SynData1: fixed[4] = ~cw[4];
      SynData2: fixed[5] = ~cw[5];
      SynData3: fixed[6] = ~cw[6];
      default:  fixed    = cw;
    endcase
    return fixed[6:3];
  endfunction

endpackage

/* src/hpd_code_if.sv */
interface hpd_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;

  modport source (output valid, output code_byte, output last_byte, input ready);
  modport sink   (input valid, input code_byte, input last_byte, output ready);
endinterface

/* src/hpd_data_if.sv */
interface hpd_data_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_out;

  modport source (output valid, output data_byte, output last_out, input ready);
  modport sink   (input valid, input data_byte, input last_out, output ready);
endinterface

/* src/hpd_unpack.sv */
`include "hamming74_packed_decoder_unit_macros.svh"

module hpd_unpack (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic [7:0]        code_byte_i,
  input  logic              last_byte_i,
  output hpd_pkg::hpd_push_t push_o
);
  import hpd_pkg::*;

  logic [StoreW-1:0]   store_q, store_d;
  logic [PendCntW-1:0] cnt_q, cnt_d;
  logic [3:0]          held_nib_q, held_nib_d;
  logic                held_q, held_d;

  logic [WinWidth-1:0] win;
  logic                two_cw;
  logic [3:0]          nib0, nib1;
  logic                r0_valid;
  logic [7:0]          r0_byte;
  logic                hold_after;
  logic [3:0]          nib_after;
  logic                tail_valid;
  hpd_result_t         tail_res;

  assign win    = {{(WinWidth-StoreW){1'b0}}, store_q}
                | ({{(WinWidth-8){1'b0}}, code_byte_i} << cnt_q);
  assign two_cw = (cnt_q == PendFull);
  assign nib0   = hpd_decode_cw(win[CwWidth-1:0]);
  assign nib1   = hpd_decode_cw(win[2*CwWidth-1:CwWidth]);

  always_comb begin
    r0_valid   = 1'b0;
    r0_byte    = {nib0, held_nib_q};
    hold_after = held_q;
    nib_after  = held_nib_q;
    if (two_cw) begin
      r0_valid = 1'b1;
      if (held_q) begin
        r0_byte   = {nib0, held_nib_q};
        nib_after = nib1;
      end else begin
        r0_byte    = {nib1, nib0};
        hold_after = 1'b0;
        nib_after  = 4'd0;
      end
    end else if (held_q) begin
      r0_valid   = 1'b1;
      hold_after = 1'b0;
      nib_after  = 4'd0;
    end else begin
      hold_after = 1'b1;
      nib_after  = nib0;
    end
  end

  // Flush the odd nibble on the final byte
  assign tail_valid         = last_byte_i && hold_after;
  assign tail_res.data_byte = {4'd0, nib_after};
  assign tail_res.last_out  = 1'b1;

  always_comb begin
    push_o = '0;
    if (r0_valid) begin
      push_o.valid_a            = fire_i;
      push_o.res_a.data_byte    = r0_byte;
      push_o.res_a.last_out     = last_byte_i && !tail_valid;
      push_o.valid_b            = fire_i && tail_valid;
      push_o.res_b              = tail_res;
    end else begin
      push_o.valid_a = fire_i && tail_valid;
      push_o.res_a   = tail_res;
    end
  end

  always_comb begin
    store_d    = store_q;
    cnt_d      = cnt_q;
    held_d     = held_q;
    held_nib_d = held_nib_q;
    if (fire_i) begin
      if (last_byte_i) begin
        store_d    = '0;
        cnt_d      = '0;
        held_d     = 1'b0;
        held_nib_d = 4'd0;
      end else begin
        store_d    = two_cw ? '0 : win[CwWidth+StoreW-1:CwWidth];
        cnt_d      = two_cw ? '0 : cnt_q + PendCntW'(1);
        held_d     = hold_after;
        held_nib_d = nib_after;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q    <= '0;
      cnt_q      <= '0;
      held_q     <= 1'b0;
      held_nib_q <= 4'd0;
    end else begin
      store_q    <= store_d;
      cnt_q      <= cnt_d;
      held_q     <= held_d;
      held_nib_q <= held_nib_d;
    end
  end

  `HPD_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q <= PendFull, "pending bit count above six")
  `HPD_ASSERT_NXT(a_last_clears, fire_i && last_byte_i, cnt_q == '0 && !held_q,
                  "state not cleared after final byte")
  `HPD_ASSERT_IMP(a_second_is_final, push_o.valid_b,
                  push_o.valid_a && last_byte_i && push_o.res_b.last_out,
                  "second result without final byte")

endmodule

/* src/hpd_result_fifo.sv */
`include "hamming74_packed_decoder_unit_macros.svh"

module hpd_result_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hpd_pkg::hpd_push_t push_i,
  output logic               room_o,
  hpd_data_if.source         data_o
);
  import hpd_pkg::*;

  hpd_result_t         mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;
  logic                pop;
  logic [FifoPtrW-1:0] wr_ptr_b;

  assign pop      = data_o.valid && data_o.ready;
  assign wr_ptr_b = wr_ptr_q + FifoPtrW'(1);

  // Room for the worst case of two results from one byte
  assign room_o = (cnt_q <= FifoCntW'(FifoDepth - 2));

  assign data_o.valid     = (cnt_q != '0);
  assign data_o.data_byte = mem_q[rd_ptr_q].data_byte;
  assign data_o.last_out  = mem_q[rd_ptr_q].last_out;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.valid_b) begin
      wr_ptr_d = wr_ptr_q + FifoPtrW'(2);
    end else if (push_i.valid_a) begin
      wr_ptr_d = wr_ptr_b;
    end
    rd_ptr_d = pop ? rd_ptr_q + FifoPtrW'(1) : rd_ptr_q;
    cnt_d    = cnt_q + FifoCntW'(push_i.valid_a) + FifoCntW'(push_i.valid_b)
             - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid_a) begin
      mem_q[wr_ptr_q] <= push_i.res_a;
    end
    if (push_i.valid_b) begin
      mem_q[wr_ptr_b] <= push_i.res_b;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  `HPD_ASSERT_IMP(a_fifo_bound, 1'b1, cnt_q <= FifoCntW'(FifoDepth), "result queue overflow")
  `HPD_ASSERT_IMP(a_push_order, push_i.valid_b, push_i.valid_a, "second push without first")
  `HPD_ASSERT_NXT(a_pop_drains, pop && !push_i.valid_a,
                  cnt_q == $past(cnt_q) - FifoCntW'(1), "pop did not drain queue")

endmodule

/* src/hamming74_packed_decoder_unit.sv */
// Hamming(7,4) packed-stream decoder.
// code_i carries bytes of a stream of 7-bit codewords packed LSB first, with
// last_byte marking the final byte of a stream. data_o carries decoded bytes,
// first nibble low, with last_out on the final result of a stream. Both
// channels use valid/ready; a transaction happens when both are high.
// Each codeword is syndrome-checked, a single data-bit error is corrected,
// and its four data bits are kept. On the final byte an odd nibble is sent
// with a zero high nibble and leftover partial bits are dropped.
// A result passes through the input register and is then decoded into the
// result queue, from which it is offered on data_o.
// Throughput: one input byte per cycle while the result queue has room, set
// by the single decode pass; one byte yields at most two results, so a
// four-entry result queue absorbs them. When the receiver stalls, the queue
// fills, code_i.ready drops once fewer than two entries are free, and the
// input register holds its byte. Reset clears the input valid flag, the bit
// store, the held nibble and the queue; the first byte after reset, or after
// a final byte, starts a new stream.
module hamming74_packed_decoder_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  hpd_code_if.sink   code_i,
  hpd_data_if.source data_o
);
  import hpd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q, in_byte_d;
  logic       in_last_q, in_last_d;
  logic       accept;
  logic       advance;
  logic       room;
  hpd_push_t  push;

  // Advance the registered byte into the decoder once the queue has room
  assign advance      = in_valid_q && room;
  assign code_i.ready = !in_valid_q || advance;
  assign accept       = code_i.valid && code_i.ready;

  always_comb begin
    in_valid_d = in_valid_q;
    in_byte_d  = in_byte_q;
    in_last_d  = in_last_q;
    if (accept) begin
      in_valid_d = 1'b1;
      in_byte_d  = code_i.code_byte;
      in_last_d  = code_i.last_byte;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk_i) begin
    in_byte_q <= in_byte_d;
    in_last_q <= in_last_d;
  end

  hpd_unpack u_unpack (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (advance),
    .code_byte_i(in_byte_q),
    .last_byte_i(in_last_q),
    .push_o     (push)
  );

  hpd_result_fifo u_result_fifo (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .push_i(push),
    .room_o(room),
    .data_o(data_o)
  );

endmodule

/* verif/tb.sv */
module tb;

  // Syndrome masks over one 7-bit codeword, parity bits 0..2, data bits 3..6
  localparam logic [6:0] ChkMask0 = 7'd105;
  localparam logic [6:0] ChkMask1 = 7'd58;
  localparam logic [6:0] ChkMask2 = 7'd116;

  // Syndromes that point at a data bit of the codeword
  localparam logic [2:0] SynFlipBit3 = 3'd3;
  localparam logic [2:0] SynFlipBit4 = 3'd6;
  localparam logic [2:0] SynFlipBit5 = 3'd7;
  localparam logic [2:0] SynFlipBit6 = 3'd5;

  localparam int unsigned RandomItems  = 900;
  localparam int unsigned StallAtCount = 300;
  localparam int unsigned StallCycles  = 400;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned TailCycles   = 8;

  // Predict decoded bytes from accepted code bytes and hold them in order.
  class decode_scoreboard;
    typedef struct packed {
      logic [7:0] data_byte;
      logic       last_out;
    } data_item_t;

    logic [13:0] bit_store;
    logic [3:0]  bit_count;
    logic [3:0]  held_nibble;
    logic        nibble_held;
    data_item_t  pending_q[$];
    int unsigned error_count;

    function new();
      clear_stream();
      error_count = 0;
    endfunction

    function void clear_stream();
      bit_store   = '0;
      bit_count   = '0;
      held_nibble = '0;
      nibble_held = 1'b0;
    endfunction

    function logic [3:0] correct_nibble(logic [6:0] cw);
      logic [2:0] syn;
      syn = {^(cw & ChkMask2), ^(cw & ChkMask1), ^(cw & ChkMask0)};
      case (syn)
        SynFlipBit3: cw[3] = ~cw[3];
        SynFlipBit4: cw[4] = ~cw[4];
        SynFlipBit5: cw[5] = ~cw[5];
        SynFlipBit6: cw[6] = ~cw[6];
        default: ;
      endcase
      return cw[6:3];
    endfunction

    function void note_code_byte(logic [7:0] code, logic last);
      logic [3:0]  nib;
      int unsigned pushed;
      data_item_t  item;
      pushed = 0;
      bit_store = (bit_store & ((14'd1 << bit_count) - 14'd1)) | (14'(code) << bit_count);
      bit_count = bit_count + 4'd8;
      while (bit_count >= 4'd7) begin
        nib       = correct_nibble(bit_store[6:0]);
        bit_store = bit_store >> 7;
        bit_count = bit_count - 4'd7;
        if (nibble_held) begin
          item.data_byte = {nib, held_nibble};
          item.last_out  = 1'b0;
          pending_q.push_back(item);
          pushed++;
          nibble_held = 1'b0;
          held_nibble = '0;
        end else begin
          held_nibble = nib;
          nibble_held = 1'b1;
        end
      end
      if (last) begin
        // Flush an odd nibble with a zero high half; drop partial bits.
        if (nibble_held) begin
          item.data_byte = {4'h0, held_nibble};
          item.last_out  = 1'b0;
          pending_q.push_back(item);
          pushed++;
        end
        if (pushed > 0) pending_q[pending_q.size() - 1].last_out = 1'b1;
        clear_stream();
      end
    endfunction

    function void check_data_byte(logic [7:0] data, logic last);
      data_item_t want;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result data_byte=%02h last_out=%0b", $time, data, last);
        error_count++;
      end else begin
        want = pending_q.pop_front();
        if (data !== want.data_byte) begin
          $display("%0t: data_byte mismatch, expected %02h, actual %02h",
                   $time, want.data_byte, data);
          error_count++;
        end
        if (last !== want.last_out) begin
          $display("%0t: last_out mismatch, expected %0b, actual %0b",
                   $time, want.last_out, last);
          error_count++;
        end
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  hpd_code_if code_if ();
  hpd_data_if data_if ();

  hamming74_packed_decoder_unit dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .code_i (code_if),
    .data_o (data_if)
  );

  decode_scoreboard sb = new();

  logic [7:0]  stream_q[$];
  logic [6:0]  cw_q[$];
  int unsigned items_sent;
  bit          send_burst;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Fail the run if it hangs anywhere.
  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  function automatic logic [6:0] encode_nibble(logic [3:0] d);
    logic [6:0] cw;
    cw    = {d, 3'b000};
    cw[0] = ^(cw & ChkMask0);
    cw[1] = ^(cw & ChkMask1);
    cw[2] = ^(cw & ChkMask2);
    return cw;
  endfunction

  // Pack cw_q LSB first into stream_q; pad the tail byte with random bits.
  task automatic pack_codewords();
    logic [7:0]  acc;
    int unsigned nbits;
    acc   = '0;
    nbits = 0;
    foreach (cw_q[k]) begin
      for (int i = 0; i < 7; i++) begin
        acc[nbits] = cw_q[k][i];
        nbits++;
        if (nbits == 8) begin
          stream_q.push_back(acc);
          nbits = 0;
        end
      end
    end
    if (nbits > 0) begin
      for (int i = nbits; i < 8; i++) acc[i] = $urandom_range(0, 1);
      stream_q.push_back(acc);
    end
    cw_q.delete();
  endtask

  // Offer one code byte and hold it until the transaction completes.
  task automatic send_code_byte(input logic [7:0] code, input logic last);
    int unsigned gap;
    gap = send_burst ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      code_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    code_if.valid     <= 1'b1;
    code_if.code_byte <= code;
    code_if.last_byte <= last;
    do @(posedge clk_i); while (!code_if.ready);
    sb.note_code_byte(code, last);
    items_sent++;
  endtask

  // Send stream_q as one stream, marking its final byte.
  task automatic send_stream();
    foreach (stream_q[i]) send_code_byte(stream_q[i], i == stream_q.size() - 1);
    stream_q.delete();
  endtask

  task automatic send_random_stream();
    int unsigned n;
    logic [6:0]  cw;
    send_burst = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 3) != 0) begin
      // Mostly well-formed codewords, some with one or two flipped bits.
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(17, 40) : $urandom_range(1, 16);
      repeat (n) begin
        cw = encode_nibble(4'($urandom_range(0, 15)));
        if ($urandom_range(0, 2) == 0) cw[$urandom_range(0, 6)] ^= 1'b1;
        if ($urandom_range(0, 9) == 0) cw[$urandom_range(0, 6)] ^= 1'b1;
        cw_q.push_back(cw);
      end
      pack_codewords();
    end else begin
      // Raw noise bytes.
      n = $urandom_range(1, 12);
      repeat (n) stream_q.push_back(8'($urandom_range(0, 255)));
    end
    send_stream();
  endtask

  // Receiver: random stalls, burst stretches, and one long hold-off that
  // backs the result queue up into the input channel.
  initial begin
    int unsigned gap;
    int unsigned seen;
    bit          recv_burst;
    seen       = 0;
    recv_burst = 1'b0;
    data_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (seen % 64 == 0) recv_burst = ($urandom_range(0, 3) == 0);
      if (seen == StallAtCount) gap = StallCycles;
      else gap = recv_burst ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
        data_if.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      data_if.ready <= 1'b1;
      do @(posedge clk_i); while (!data_if.valid);
      sb.check_data_byte(data_if.data_byte, data_if.last_out);
      seen++;
    end
  end

  initial begin
    int unsigned guard;
    items_sent = 0;
    send_burst = 1'b0;
    rst_ni            <= 1'b0;
    code_if.valid     <= 1'b0;
    code_if.code_byte <= '0;
    code_if.last_byte <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte streams at both extremes: one nibble, flushed odd.
    stream_q.push_back(8'h00);
    send_stream();
    stream_q.push_back(8'hFF);
    send_stream();

    // Clean codeword, then an error at every bit position, then a double
    // error; nine codewords leave an odd nibble and a partial tail.
    cw_q.push_back(encode_nibble(4'h6));
    for (int i = 0; i < 7; i++) cw_q.push_back(encode_nibble(4'(9 + i)) ^ (7'd1 << i));
    cw_q.push_back(encode_nibble(4'hF) ^ 7'b0011000);
    pack_codewords();
    send_stream();

    // Two bytes: two codewords make one byte, two leftover bits drop.
    stream_q.push_back(8'h5A);
    stream_q.push_back(8'hA5);
    send_stream();

    // Eight codewords fill seven bytes exactly, nothing left at the end.
    for (int i = 0; i < 8; i++) cw_q.push_back(encode_nibble(4'(i * 2 + 1)));
    pack_codewords();
    send_stream();

    while (items_sent < RandomItems) send_random_stream();
    code_if.valid <= 1'b0;

    // Drain, then keep clocking for TailCycles to show stray results.
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < DrainLimit) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (TailCycles) @(posedge clk_i);
    if (sb.pending_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, sb.pending_q.size());
      sb.error_count++;
    end
    if (sb.error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+src
src/hpd_pkg.sv
src/hpd_code_if.sv
src/hpd_data_if.sv
src/hpd_unpack.sv
src/hpd_result_fifo.sv
src/hamming74_packed_decoder_unit.sv
verif/tb.sv
